@@ sv/wsft_pkg.sv @@
// wsft_pkg: shared constants, the division cell type and the sine table
// for the wavetable sine block; no dependencies
`timescale 1ns / 1ps

package wsft_pkg;

  // table geometry and field widths
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int TIME_W     = 32;
  localparam int SAMPLE_W   = 16;

  // cells needed to reduce a full time word modulo the period
  localparam int MOD_CELLS = TIME_W;

  localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(1000);

  // fixed point constants for building the table
  localparam logic [63:0] HALF_PI_Q62  = 64'h6487ED5110B4611A;
  localparam int          TAYLOR_TERMS = 12;
  localparam logic [9:0]  TAYLOR_DIV [TAYLOR_TERMS] = '{
    10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
    10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600
  };

  // data carried from one division cell to the next
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] feed;
    logic [IDX_W-1:0]  quo;
  } wsft_cell_t;

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [TABLE_SIZE];

  // (a * b) >> 62 for a, b below 2^63
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'b0, a} * {64'b0, b};
    return prod[125:62];
  endfunction

  // unsigned long division by shift and subtract, for building the table
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sine of a first quadrant angle, q62 in and out
  function automatic logic [63:0] sin_q62(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      term = div_u64(mul_q62(term, x2), {54'b0, TAYLOR_DIV[k]});
      if ((k % 2) == 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // rounded 32767 * sin((pi/2) * num / TABLE_SIZE), num in [0, TABLE_SIZE]
  function automatic logic [SAMPLE_W-1:0] quarter_sine(logic [63:0] num);
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] scaled;
    logic [63:0] mag;
    frac   = ((num << 46) / 64'(TABLE_SIZE)) << 16;
    x      = mul_q62(HALF_PI_Q62, frac);
    s      = sin_q62(x);
    scaled = mul_q62(s, 64'd32767 << 47);
    mag    = (scaled + (64'd1 << 46)) >> 47;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[SAMPLE_W-1:0];
  endfunction

  // full table, built at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] r;
    logic [SAMPLE_W-1:0] v;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      m = 64'(4 * i);
      q = m / 64'(TABLE_SIZE);
      r = m % 64'(TABLE_SIZE);
      if (q[0]) begin
        v = quarter_sine(64'(TABLE_SIZE) - r);
      end else begin
        v = quarter_sine(r);
      end
      if (q[1]) begin
        v = -v;
      end
      rom[i] = v;
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ sv/wsft_div_cell.sv @@
// wsft_div_cell: one restoring division step with its pipeline register
// depends on wsft_pkg
`timescale 1ns / 1ps

module wsft_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [wsft_pkg::TIME_W-1:0] period_i,
  input  wsft_pkg::wsft_cell_t      cell_i,
  output wsft_pkg::wsft_cell_t      cell_o
);

  logic                          valid_q;
  logic [wsft_pkg::TIME_W-1:0]   rem_d, rem_q;
  logic [wsft_pkg::TIME_W-1:0]   feed_d, feed_q;
  logic [wsft_pkg::IDX_W-1:0]    quo_d, quo_q;
  logic [wsft_pkg::TIME_W:0]     trial;
  logic [wsft_pkg::TIME_W+1:0]   diff;
  logic                          ge;

  // shift in the next dividend bit and try subtracting the period
  always_comb begin
    trial  = {cell_i.rem, cell_i.feed[wsft_pkg::TIME_W-1]};
    diff   = {1'b0, trial} - {2'b0, period_i};
    ge     = ~diff[wsft_pkg::TIME_W+1];
    rem_d  = ge ? diff[wsft_pkg::TIME_W-1:0] : trial[wsft_pkg::TIME_W-1:0];
    feed_d = {cell_i.feed[wsft_pkg::TIME_W-2:0], 1'b0};
    quo_d  = {cell_i.quo[wsft_pkg::IDX_W-2:0], ge};
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      feed_q <= feed_d;
      quo_q  <= quo_d;
    end
  end

  assign cell_o = '{valid: valid_q, rem: rem_q, feed: feed_q, quo: quo_q};

endmodule

@@ sv/wavetable_sine_from_time.sv @@
// wavetable_sine_from_time: time to sine sample through a chain of division cells
// one item per cycle while the output item is not held
// 32 cells reduce time modulo the period, a constant multiply scales the
// remainder, log2(TABLE_SIZE) cells form the index, a registered table read ends it
// reset clears all valid bits and sets the period to 1000; no clearing pass
// depends on wsft_pkg and wsft_div_cell
`timescale 1ns / 1ps

module wavetable_sine_from_time (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                period_ticks_we_i,
  input  logic [wsft_pkg::TIME_W-1:0]         period_ticks_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [wsft_pkg::TIME_W-1:0]         time_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wsft_pkg::SAMPLE_W-1:0] sample_out_o
);

  localparam int SCALE_W = wsft_pkg::TIME_W + wsft_pkg::IDX_W;

  logic [wsft_pkg::TIME_W-1:0]           period_q;
  logic                                  pipe_en;
  wsft_pkg::wsft_cell_t                  mod_c  [wsft_pkg::MOD_CELLS+1];
  wsft_pkg::wsft_cell_t                  frac_c [wsft_pkg::IDX_W+1];
  logic [SCALE_W-1:0]                    scaled;
  logic                                  scale_valid_q;
  logic [wsft_pkg::TIME_W-1:0]           scale_rem_q;
  logic [wsft_pkg::TIME_W-1:0]           scale_feed_q;
  logic                                  out_valid_q;
  logic signed [wsft_pkg::SAMPLE_W-1:0]  sample_q;

  // period register, a zero period acts as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= wsft_pkg::PERIOD_RESET;
    end else if (period_ticks_we_i) begin
      period_q <= (period_ticks_i == '0) ? wsft_pkg::TIME_W'(1) : period_ticks_i;
    end
  end

  // whole pipe moves unless the output item is held
  assign pipe_en    = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~pipe_en;

  // modulo chain: time bits enter msb first
  assign mod_c[0] = '{valid: in_valid_i, rem: '0, feed: time_value_i, quo: '0};

  for (genvar g = 0; g < wsft_pkg::MOD_CELLS; g++) begin : g_mod
    wsft_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (pipe_en),
      .period_i (period_q),
      .cell_i   (mod_c[g]),
      .cell_o   (mod_c[g+1])
    );
  end

  // scale remainder by the table size, upper part seeds the index division
  assign scaled = SCALE_W'(mod_c[wsft_pkg::MOD_CELLS].rem) * SCALE_W'(wsft_pkg::TABLE_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_valid_q <= 1'b0;
    end else if (pipe_en) begin
      scale_valid_q <= mod_c[wsft_pkg::MOD_CELLS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      scale_rem_q  <= scaled[SCALE_W-1:wsft_pkg::IDX_W];
      scale_feed_q <= {scaled[wsft_pkg::IDX_W-1:0],
                       (wsft_pkg::TIME_W - wsft_pkg::IDX_W)'(0)};
    end
  end

  // index chain: one quotient bit per cell
  assign frac_c[0] = '{valid: scale_valid_q, rem: scale_rem_q, feed: scale_feed_q, quo: '0};

  for (genvar g = 0; g < wsft_pkg::IDX_W; g++) begin : g_frac
    wsft_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (pipe_en),
      .period_i (period_q),
      .cell_i   (frac_c[g]),
      .cell_o   (frac_c[g+1])
    );
  end

  // table read into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= frac_c[wsft_pkg::IDX_W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sample_q <= wsft_pkg::SINE_ROM[frac_c[wsft_pkg::IDX_W].quo];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;

`ifndef NO_ASSERTIONS
  // the divisor can never be zero
  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q != '0)
    else $error("period register holds zero");

  // a held output item must hold the input side too
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input accepted while output is held");

  // the modulo chain leaves a remainder below the period
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_c[wsft_pkg::MOD_CELLS].valid |-> (mod_c[wsft_pkg::MOD_CELLS].rem < period_q))
    else $error("remainder not below period");
`endif

endmodule
